[sv/rzs_pkg.sv]
// Shared types and constants for the running z-score outlier flag block.
// Used by rzs_div and running_zscore_outlier_flag_core; depends on nothing.
package rzs_pkg;

	// Default parameter values
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 32;

	// Shared divider geometry
	localparam int DIV_NW = 80;
	localparam int DIV_DW = 64;
	localparam int DIV_CW = 7;

	// Fixed field and state widths
	localparam int SQS_W      = 64;
	localparam int THR_W      = 15;
	localparam int Z_W        = 16;
	localparam int MEAN_OUT_W = 24;
	localparam int STD_OUT_W  = 24;
	localparam int TOT_W      = 32;

	localparam logic [THR_W-1:0] THR_RESET = 15'd768;

	// Request to the divider
	typedef struct packed {
		logic              start;
		logic [DIV_CW-1:0] iters;
	} div_req_t;

	// Status from the divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/rzs_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on rzs_pkg. The numerator comes left-aligned; iters sets the bit count.
module rzs_div
	import rzs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output div_stat_t         stat,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              ge;

	// Form the trial remainder and compare
	always_comb begin
		trial = {rem_q, num_q[DIV_NW-1]};
		ge    = trial >= {1'b0, den_q};
	end

	// Control: count down the bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift quotient bits into the numerator register
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			num_q <= {num_q[DIV_NW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = num_q;

endmodule

[sv/running_zscore_outlier_flag_core.sv]
// Running z-score normalizer with outlier flag: top level.
// Depends on rzs_pkg and rzs_div.
//
// Input channel: in_valid/in_stall with the signed sample. A word is taken
// when in_valid is high and in_stall low; in_stall is high while a sample is
// being worked on. Output channel: out_valid/out_stall with z_score,
// is_outlier, mean_value, std_deviation and outliers_seen, one word per sample.
// Configuration: cfg_valid/cfg_ready/cfg_data write the 15-bit outlier
// threshold; cfg_ready is always high. Write it only while the block is idle.
// The single shared divider works out the mean, the mean of squares and the
// z-score in turn, each with a handoff, and the square root is taken between
// the mean of squares and the z-score. The first sample skips the variance and
// the z-score division; a later sample with zero deviation skips the z-score
// division. The result sits in an output register; a stalled receiver holds it,
// and a new sample may be taken meanwhile but the block waits at the end until
// the register frees.
// Reset clears sums, count, outlier total and the output valid flag, and sets
// the threshold to 3.0.
module running_zscore_outlier_flag_core
	import rzs_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [Z_W-1:0]         z_score,
	output logic                          is_outlier,
	output logic signed [MEAN_OUT_W-1:0]  mean_value,
	output logic [STD_OUT_W-1:0]          std_deviation,
	output logic [TOT_W-1:0]              outliers_seen,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [THR_W-1:0]              cfg_data
);

	localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
	localparam int MNUM_W = SUM_W + 10;
	localparam int MAG_W  = SAMPLE_BITS + 8;
	localparam int MW     = SAMPLE_BITS + 9;
	localparam int SQ_W   = 2 * SAMPLE_BITS;
	localparam int M2_W   = 2 * MAG_W;
	localparam int DIFF_W = SAMPLE_BITS + 10;
	localparam int ZNW    = SAMPLE_BITS + 20;

	typedef enum logic [3:0] {
		S_IDLE, S_SQR, S_UPD, S_MEAN_GO, S_MEAN_WAIT, S_M2, S_AVG_GO, S_AVG_WAIT,
		S_ROOT, S_ZPREP, S_Z_GO, S_Z_WAIT, S_FIN
	} state_t;

	state_t                      state_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic [SQ_W-1:0]             sq_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic [SQS_W-1:0]            sqs_q;
	logic [COUNT_BITS-1:0]       cnt_q;
	logic [TOT_W-1:0]            tot_q;
	logic [THR_W-1:0]            thr_q;
	logic signed [MW-1:0]        mean_q;
	logic [M2_W-1:0]             m2_q;
	logic [SQS_W-1:0]            rv_q;
	logic [SQS_W-1:0]            rres_q;
	logic [SQS_W-1:0]            rbit_q;
	logic [MAG_W-1:0]            std_q;
	logic [ZNW-1:0]              znum_q;
	logic                        zneg_q;
	logic                        zzero_q;
	logic                        out_valid_q;
	logic signed [Z_W-1:0]       z_q;
	logic                        outl_q;
	logic signed [MEAN_OUT_W-1:0] mean_out_q;
	logic [STD_OUT_W-1:0]        std_out_q;

	div_req_t          dreq;
	div_stat_t         dstat;
	logic [DIV_NW-1:0] dnum;
	logic [DIV_DW-1:0] dden;
	logic [DIV_NW-1:0] dquo;

	logic [SAMPLE_BITS-1:0]  smag;
	logic [SQS_W:0]          sqs_nx;
	logic                    upd_ok;
	logic [SUM_W-1:0]        msum;
	logic [MNUM_W-1:0]       mnum;
	logic [MAG_W-1:0]        mq;
	logic [MAG_W-1:0]        mm;
	logic [SQS_W-1:0]        sqavg;
	logic [SQS_W-1:0]        rtry;
	logic                    rge;
	logic [SQS_W-1:0]        rres_nx;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]       dmag;
	logic [ZNW-1:0]          zm;
	logic [Z_W:0]            az;
	logic signed [Z_W-1:0]   z_nx;
	logic                    outl_nx;
	logic signed [33:0]      mext;
	logic [31:0]             sext;
	logic                    out_free;

	// Shared divider
	rzs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.num    (dnum),
		.den    (dden),
		.stat   (dstat),
		.quo    (dquo)
	);

	// Select divider operands by step
	always_comb begin
		dreq.start = 1'b0;
		dreq.iters = DIV_CW'(ZNW);
		dnum       = DIV_NW'(znum_q) << (DIV_NW - ZNW);
		dden       = DIV_DW'({std_q, 1'b0});
		case (state_q)
			S_MEAN_GO: begin
				dreq.start = 1'b1;
				dreq.iters = DIV_CW'(MNUM_W);
				dnum       = DIV_NW'(mnum) << (DIV_NW - MNUM_W);
				dden       = DIV_DW'({cnt_q, 1'b0});
			end
			S_AVG_GO: begin
				dreq.start = 1'b1;
				dreq.iters = DIV_CW'(DIV_NW);
				dnum       = {sqs_q, 16'b0};
				dden       = DIV_DW'(cnt_q);
			end
			S_Z_GO: begin
				dreq.start = 1'b1;
			end
			default: begin
				dreq.start = 1'b0;
			end
		endcase
	end

	// Per-step arithmetic
	always_comb begin
		smag    = smp_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp_q) : SAMPLE_BITS'(smp_q);
		sqs_nx  = {1'b0, sqs_q} + (SQS_W+1)'(sq_q);
		upd_ok  = !sqs_nx[SQS_W] && (cnt_q != '1);
		msum    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		mnum    = MNUM_W'({msum, 9'b0}) + MNUM_W'(cnt_q);
		mq      = dquo[MAG_W-1:0];
		mm      = mean_q[MW-1] ? MAG_W'(-mean_q) : MAG_W'(mean_q);
		sqavg   = dquo[SQS_W-1:0];
		rtry    = rres_q + rbit_q;
		rge     = rv_q >= rtry;
		rres_nx = rge ? (rres_q >> 1) + rbit_q : rres_q >> 1;
		diff    = DIFF_W'($signed({smp_q, 8'b0})) - DIFF_W'(mean_q);
		dmag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		zm      = dquo[ZNW-1:0];
		// Saturate the magnitude, then apply the sign
		if (zzero_q) begin
			az = '0;
		end else if (zneg_q) begin
			az = (zm > ZNW'(32768)) ? (Z_W+1)'(32768) : zm[Z_W:0];
		end else begin
			az = (zm > ZNW'(32767)) ? (Z_W+1)'(32767) : zm[Z_W:0];
		end
		z_nx    = zneg_q ? Z_W'(-az) : Z_W'(az);
		outl_nx = az > (Z_W+1)'(thr_q);
		mext    = 34'(mean_q);
		sext    = 32'(std_q);
		out_free = !out_valid_q || !out_stall;
	end

	// Sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			sqs_q       <= '0;
			cnt_q       <= '0;
			tot_q       <= '0;
			thr_q       <= THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			// Raise valid on a new word, drop it once the word is taken
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						smp_q   <= sample;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					sq_q    <= SQ_W'(smag * smag);
					state_q <= S_UPD;
				end
				S_UPD: begin
					// Hold the sums once the count or square sum is full
					if (upd_ok) begin
						sum_q <= sum_q + SUM_W'(smp_q);
						sqs_q <= sqs_nx[SQS_W-1:0];
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= S_MEAN_GO;
				end
				S_MEAN_GO: begin
					state_q <= S_MEAN_WAIT;
				end
				S_MEAN_WAIT: begin
					if (dstat.done) begin
						mean_q  <= sum_q[SUM_W-1] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
						state_q <= S_M2;
					end
				end
				S_M2: begin
					m2_q <= M2_W'(mm * mm);
					if (cnt_q < COUNT_BITS'(2)) begin
						std_q   <= '0;
						state_q <= S_ZPREP;
					end else begin
						state_q <= S_AVG_GO;
					end
				end
				S_AVG_GO: begin
					state_q <= S_AVG_WAIT;
				end
				S_AVG_WAIT: begin
					// Clamp the variance at zero and seed the root
					if (dstat.done) begin
						rv_q    <= (sqavg > SQS_W'(m2_q)) ? sqavg - SQS_W'(m2_q) : '0;
						rres_q  <= '0;
						rbit_q  <= SQS_W'(1) << (SQS_W - 2);
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (rge) begin
						rv_q <= rv_q - rtry;
					end
					rres_q <= rres_nx;
					rbit_q <= rbit_q >> 2;
					if (rbit_q == SQS_W'(1)) begin
						std_q   <= rres_nx[MAG_W-1:0];
						state_q <= S_ZPREP;
					end
				end
				S_ZPREP: begin
					zneg_q <= diff[DIFF_W-1];
					znum_q <= ZNW'({dmag, 9'b0}) + ZNW'(std_q);
					if (std_q == '0) begin
						zzero_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						zzero_q <= 1'b0;
						state_q <= S_Z_GO;
					end
				end
				S_Z_GO: begin
					state_q <= S_Z_WAIT;
				end
				S_Z_WAIT: begin
					if (dstat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// Load the output word once the register is free
					if (out_free) begin
						z_q         <= z_nx;
						outl_q      <= outl_nx;
						if (outl_nx && tot_q != '1) begin
							tot_q <= tot_q + 1'b1;
						end
						if (mext > 34'sd8388607) begin
							mean_out_q <= 24'sh7FFFFF;
						end else if (mext < -34'sd8388608) begin
							mean_out_q <= 24'sh800000;
						end else begin
							mean_out_q <= mext[MEAN_OUT_W-1:0];
						end
						std_out_q <= (sext > 32'hFFFFFF) ? 24'hFFFFFF : sext[STD_OUT_W-1:0];
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign z_score       = z_q;
	assign is_outlier    = outl_q;
	assign mean_value    = mean_out_q;
	assign std_deviation = std_out_q;
	assign outliers_seen = tot_q;

`ifndef NO_ASSERTIONS
	// Divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (state_q == S_MEAN_WAIT || state_q == S_AVG_WAIT ||
		state_q == S_Z_WAIT))
		else $error("divider done outside a wait step");

	// A new output word comes only from the final step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("output word loaded outside the final step");

	// Outlier total never goes down
	a_tot_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> tot_q >= $past(tot_q))
		else $error("outlier total decreased");

	// Sample count never goes down
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q >= $past(cnt_q))
		else $error("sample count decreased");
`endif

endmodule
